/* rtl/core/svt3_pkg.sv */
// Shared types and constants for the 3-D summed-volume table.
// Configuration register codes and the per-stage flag group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svt3_pkg;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int ROWS_CFG_W   = 9;
  localparam int COLS_CFG_W   = 9;
  localparam int PLANES_CFG_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS   = 2'd0,
    CFG_NUM_COLS   = 2'd1,
    CFG_NUM_PLANES = 2'd2
  } cfg_reg_e;

  // Position flags that ride along with a voxel through the pipeline
  typedef struct packed {
    logic c_first;  // column zero: row running sum restarts
    logic r_nz;     // row above exists
    logic p_nz;     // previous plane exists
    logic last;     // final voxel of the volume
  } flags_t;

endpackage : svt3_pkg

`default_nettype wire

/* rtl/core/svt3_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered, read-first on collision.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module svt3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the last read while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : svt3_ram

`default_nettype wire

/* rtl/core/summed_volume_table_3d.sv */
// Streaming 3-D summed-volume table: inclusive prefix sum per voxel.
// Each stage is registered; throughput one voxel per cycle while m_axis_tready does not stall the output.
// Stages: running-row RAM read/add, previous-row buffer read/add, previous-plane add.
// Reset: dimensions at their maximum, scan position zero. Buffers are not cleared:
// every entry is written earlier in the same volume before it is read.
// Depends on svt3_pkg and svt3_ram.
`timescale 1ns / 1ps
`default_nettype none

module summed_volume_table_3d #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_PLANES = 64,
  parameter int VOXEL_BITS = 16,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int PW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1,
  localparam int RS_W  = VOXEL_BITS + CW,
  localparam int P2_W  = RS_W + RW,
  localparam int SUM_W = P2_W + PW,
  localparam int IN_W  = ((VOXEL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SUM_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [svt3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [svt3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // voxel stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,   // [VOXEL_BITS-1:0] voxel
  // result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,   // [SUM_W-1:0] volume_sum
  output logic                           m_axis_tlast    // last_voxel
);

  import svt3_pkg::*;

  localparam int BUF_DEPTH = MAX_COLS * MAX_PLANES;
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  function automatic int unsigned last_index(input logic [CFG_DATA_W-1:0] val,
                                             input int unsigned limit);
    int unsigned v;
    v = 32'(val);
    if (v == 0) return 0;
    else if (v > limit) return limit - 1;
    else return v - 1;
  endfunction

  // ---------------- configuration and scan position ----------------
  logic [RW-1:0] r_last_q, r_last_d, r_q, r_d;
  logic [CW-1:0] c_last_q, c_last_d, c_q, c_d;
  logic [PW-1:0] p_last_q, p_last_d, p_q, p_d;
  logic          restart;
  logic          adv, acc;
  flags_t        in_flags;
  logic [AW-1:0] in_addr;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign acc = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  always_comb begin
    r_last_d = r_last_q;
    c_last_d = c_last_q;
    p_last_d = p_last_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_NUM_ROWS: begin
          r_last_d = RW'(last_index(CFG_DATA_W'(cfg_data_i[ROWS_CFG_W-1:0]), MAX_ROWS));
          restart  = 1'b1;
        end
        CFG_NUM_COLS: begin
          c_last_d = CW'(last_index(CFG_DATA_W'(cfg_data_i[COLS_CFG_W-1:0]), MAX_COLS));
          restart  = 1'b1;
        end
        CFG_NUM_PLANES: begin
          p_last_d = PW'(last_index(CFG_DATA_W'(cfg_data_i[PLANES_CFG_W-1:0]),
                                    MAX_PLANES));
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    in_flags.c_first = (c_q == '0);
    in_flags.r_nz    = (r_q != '0);
    in_flags.p_nz    = (p_q != '0);
    in_flags.last    = (r_q == r_last_q) && (c_q == c_last_q) && (p_q == p_last_q);
    in_addr          = AW'(32'(c_q) * MAX_PLANES + 32'(p_q));
  end

  // advance plane innermost, then column, then row; wrap at end of volume; a dimension write restarts at zero
  always_comb begin
    r_d = r_q;
    c_d = c_q;
    p_d = p_q;
    if (restart) begin
      r_d = '0;
      c_d = '0;
      p_d = '0;
    end else if (acc) begin
      if (p_q == p_last_q) begin
        p_d = '0;
        if (c_q == c_last_q) begin
          c_d = '0;
          r_d = (r_q == r_last_q) ? '0 : r_q + 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
      end else begin
        p_d = p_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_last_q <= RW'(MAX_ROWS - 1);
      c_last_q <= CW'(MAX_COLS - 1);
      p_last_q <= PW'(MAX_PLANES - 1);
      r_q      <= '0;
      c_q      <= '0;
      p_q      <= '0;
    end else begin
      r_last_q <= r_last_d;
      c_last_q <= c_last_d;
      p_last_q <= p_last_d;
      r_q      <= r_d;
      c_q      <= c_d;
      p_q      <= p_d;
    end
  end

  // ---------------- stage 1: running sum along the row ----------------
  logic                         s1_vld_q;
  logic signed [VOXEL_BITS-1:0] s1_v_q;
  logic [PW-1:0]                s1_p_q;
  logic [AW-1:0]                s1_addr_q;
  flags_t                       s1_flags_q;
  logic                         fwd1_q;
  logic signed [RS_W-1:0]       fwd1_data_q;
  logic signed [RS_W-1:0]       rs_rdata, rs_op, rowsum;
  logic                         rs_we;

  assign rs_we  = adv && s1_vld_q;
  assign rs_op  = fwd1_q ? fwd1_data_q : rs_rdata;
  assign rowsum = s1_flags_q.c_first ? RS_W'(s1_v_q) : rs_op + RS_W'(s1_v_q);

  svt3_ram #(
    .WIDTH (RS_W),
    .DEPTH (MAX_PLANES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (s1_p_q),
    .wdata_i (rowsum),
    .re_i    (acc),
    .raddr_i (p_q),
    .rdata_o (rs_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      fwd1_q   <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc;
      // the entry is written at this same edge; the RAM read misses it
      fwd1_q   <= acc && s1_vld_q && (s1_p_q == p_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_v_q      <= s_axis_tdata[VOXEL_BITS-1:0];
      s1_p_q      <= p_q;
      s1_addr_q   <= in_addr;
      s1_flags_q  <= in_flags;
      fwd1_data_q <= rowsum;
    end
  end

  // ---------------- stage 2: add previous row's 2-D sum ----------------
  logic                   s2_vld_q;
  logic signed [RS_W-1:0] s2_rs_q;
  logic [AW-1:0]          s2_addr_q;
  flags_t                 s2_flags_q;
  logic                   fwd2_q;
  logic signed [P2_W-1:0] fwd2_data_q;
  logic signed [P2_W-1:0] pr_rdata, pr_op, plane2d;
  logic                   pr_we;

  assign pr_we   = adv && s2_vld_q;
  assign pr_op   = fwd2_q ? fwd2_data_q : pr_rdata;
  assign plane2d = P2_W'(s2_rs_q) + (s2_flags_q.r_nz ? pr_op : '0);

  svt3_ram #(
    .WIDTH (P2_W),
    .DEPTH (BUF_DEPTH)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (s2_addr_q),
    .wdata_i (plane2d),
    .re_i    (adv),
    .raddr_i (s1_addr_q),
    .rdata_o (pr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      fwd2_q   <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
      fwd2_q   <= s2_vld_q && (s2_addr_q == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rs_q     <= rowsum;
      s2_addr_q   <= s1_addr_q;
      s2_flags_q  <= s1_flags_q;
      fwd2_data_q <= plane2d;
    end
  end

  // ---------------- stage 3: add previous plane, output register ----------------
  logic                    out_vld_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s2_vld_q;
    end
  end

  // sum_q keeps the previous voxel's result until the next voxel lands
  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q) begin
      sum_q  <= SUM_W'(plane2d) + (s2_flags_q.p_nz ? sum_q : '0);
      last_q <= s2_flags_q.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'(unsigned'(sum_q));
  assign m_axis_tlast  = last_q;

  // ---------------- assertions ----------------
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_q <= p_last_q) && (c_q <= c_last_q) && (r_q <= r_last_q))
    else $error("scan position beyond configured volume");

  a_fwd1_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd1_q |-> s1_vld_q)
    else $error("row-sum forward without a voxel in stage 1");

  a_acc_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_vld_q)
    else $error("accepted voxel lost before stage 1");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !adv) |=> s2_vld_q)
    else $error("stage 2 voxel dropped during stall");

endmodule : summed_volume_table_3d

`default_nettype wire

/* tb/sv/volume_sum_checker.sv */
`timescale 1ns / 1ps
// Result checker for summed_volume_table_3d: follows register writes and voxel transfers,
// predicts each inclusive 3-D prefix sum and compares it with the result stream.
// Depends on svt3_pkg for the register codes and port widths.

module volume_sum_checker #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_PLANES = 64,
  parameter int VOXEL_BITS = 16,
  parameter int SUM_W      = 38,
  parameter int IN_W       = 16,
  parameter int OUT_W      = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [svt3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svt3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [IN_W-1:0]                 s_tdata_i,   // [VOXEL_BITS-1:0] voxel
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [OUT_W-1:0]                m_tdata_i,   // [SUM_W-1:0] volume_sum
  input  logic                            m_tlast_i,   // last_voxel
  output int                              pending_o,
  output int                              mismatches_o,
  output int                              sums_checked_o,
  output int                              volumes_done_o
);
  import svt3_pkg::*;

  typedef struct packed {
    logic signed [SUM_W-1:0] volume_sum;
    logic                    last_voxel;
  } volume_result_t;

  logic [ROWS_CFG_W-1:0]   rows_cfg;
  logic [COLS_CFG_W-1:0]   cols_cfg;
  logic [PLANES_CFG_W-1:0] planes_cfg;

  // 2-D (row x column) sums of the previous row, one per column and plane
  longint plane2d_mem [MAX_COLS*MAX_PLANES];
  longint row_acc [MAX_PLANES];
  longint prev_plane_sum;
  int     row_pos;
  int     col_pos;
  int     plane_pos;

  volume_result_t expected_sums [$];
  volume_result_t due;
  int mismatches   = 0;
  int sums_checked = 0;
  int volumes_done = 0;

  assign mismatches_o   = mismatches;
  assign sums_checked_o = sums_checked;
  assign volumes_done_o = volumes_done;

  // A zero register acts as one, an oversized one as the maximum
  function automatic int clamp_dim(int raw, int lim);
    if (raw == 0) return 1;
    return (raw > lim) ? lim : raw;
  endfunction

  task automatic restart_scan();
    for (int p = 0; p < MAX_PLANES; p++) row_acc[p] = 0;
    prev_plane_sum = 0;
    row_pos        = 0;
    col_pos        = 0;
    plane_pos      = 0;
  endtask

  task automatic predict_volume_sum(input logic [VOXEL_BITS-1:0] voxel);
    int             rows;
    int             cols;
    int             planes;
    int             slot;
    longint         value;
    longint         rowsum;
    longint         plane2d;
    longint         total;
    volume_result_t res;
    rows   = clamp_dim(rows_cfg, MAX_ROWS);
    cols   = clamp_dim(cols_cfg, MAX_COLS);
    planes = clamp_dim(planes_cfg, MAX_PLANES);
    slot   = col_pos * MAX_PLANES + plane_pos;
    value  = $signed(voxel);

    rowsum = value;
    if (col_pos != 0) rowsum += row_acc[plane_pos];
    row_acc[plane_pos] = rowsum;

    plane2d = rowsum;
    if (row_pos != 0) plane2d += plane2d_mem[slot];
    plane2d_mem[slot] = plane2d;

    total = plane2d;
    if (plane_pos != 0) total += prev_plane_sum;
    prev_plane_sum = total;

    res.volume_sum = total[SUM_W-1:0];
    res.last_voxel = (row_pos == rows - 1) && (col_pos == cols - 1) &&
                     (plane_pos == planes - 1);
    expected_sums = {expected_sums, res};

    // Advance the scan: plane innermost, then column, then row; wrap at the end
    plane_pos++;
    if (plane_pos >= planes) begin
      plane_pos = 0;
      col_pos++;
      if (col_pos >= cols) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= rows) row_pos = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg   = ROWS_CFG_W'(MAX_ROWS);
      cols_cfg   = COLS_CFG_W'(MAX_COLS);
      planes_cfg = PLANES_CFG_W'(MAX_PLANES);
      restart_scan();
      expected_sums.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_ROWS: begin
            rows_cfg = cfg_data_i[ROWS_CFG_W-1:0];
            restart_scan();
          end
          CFG_NUM_COLS: begin
            cols_cfg = cfg_data_i[COLS_CFG_W-1:0];
            restart_scan();
          end
          CFG_NUM_PLANES: begin
            planes_cfg = cfg_data_i[PLANES_CFG_W-1:0];
            restart_scan();
          end
          default: ;
        endcase
      end

      if (s_tvalid_i && s_tready_i) predict_volume_sum(s_tdata_i[VOXEL_BITS-1:0]);

      if (m_tvalid_i && m_tready_i) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          $error("volume_sum: no sum expected, actual %0d", $signed(m_tdata_i[SUM_W-1:0]));
        end else begin
          due = expected_sums.pop_front();
          sums_checked++;
          if (due.last_voxel) volumes_done++;
          if (m_tdata_i[SUM_W-1:0] !== due.volume_sum) begin
            mismatches++;
            $error("volume_sum: expected %0d, actual %0d", $signed(due.volume_sum),
                   $signed(m_tdata_i[SUM_W-1:0]));
          end
          if (m_tlast_i !== due.last_voxel) begin
            mismatches++;
            $error("last_voxel: expected %0b, actual %0b", due.last_voxel, m_tlast_i);
          end
        end
      end

      pending_o <= expected_sums.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for summed_volume_table_3d: clock, reset, volume settings, voxel stimulus,
// result back-pressure and the verdict. Depends on svt3_pkg, the block and volume_sum_checker.

module tb;
  import svt3_pkg::*;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_COLS     = 256;
  localparam int MAX_PLANES   = 64;
  localparam int VOXEL_BITS   = 16;
  localparam int SUM_W        = VOXEL_BITS + $clog2(MAX_COLS) + $clog2(MAX_ROWS) +
                                $clog2(MAX_PLANES);
  localparam int IN_W         = ((VOXEL_BITS + 7) / 8) * 8;
  localparam int OUT_W        = ((SUM_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam longint TIMEOUT_NS  = 5_000_000;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_NUM_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;

  int pending;
  int mismatches;
  int sums_checked;
  int volumes_done;
  int voxels_sent  = 0;
  int reg_writes   = 0;
  bit hold_off_req = 1'b0;

  summed_volume_table_3d #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_PLANES(MAX_PLANES),
    .VOXEL_BITS(VOXEL_BITS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast)
  );

  volume_sum_checker #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_PLANES(MAX_PLANES),
    .VOXEL_BITS(VOXEL_BITS),
    .SUM_W     (SUM_W),
    .IN_W      (IN_W),
    .OUT_W     (OUT_W)
  ) sum_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .pending_o     (pending),
    .mismatches_o  (mismatches),
    .sums_checked_o(sums_checked),
    .volumes_done_o(volumes_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: FAIL");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VOXEL_BITS-1:0] random_voxel();
    case ($urandom_range(0, 19))
      0:       return {1'b0, {(VOXEL_BITS-1){1'b1}}};
      1:       return {1'b1, {(VOXEL_BITS-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return VOXEL_BITS'($urandom());
    endcase
  endfunction

  // Pick a raw register value for a dimension: sometimes zero for one, sometimes
  // oversized for the maximum, with random bits above the register width
  function automatic logic [CFG_DATA_W-1:0] encode_dim(int dim, int lim, int field_w);
    logic [CFG_DATA_W-1:0] raw;
    raw = CFG_DATA_W'(dim);
    if (dim == 1 && $urandom_range(0, 1) == 1) raw = '0;
    else if (dim == lim && $urandom_range(0, 1) == 1)
      raw = CFG_DATA_W'($urandom_range(lim + 1, (1 << field_w) - 1));
    raw = raw | CFG_DATA_W'($urandom() << field_w);
    return raw;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_volume(input logic [CFG_DATA_W-1:0] rows_raw,
                            input logic [CFG_DATA_W-1:0] cols_raw,
                            input logic [CFG_DATA_W-1:0] planes_raw);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NUM_ROWS;
    cfg_data <= rows_raw;
    @(posedge clk);
    cfg_idx  <= CFG_NUM_COLS;
    cfg_data <= cols_raw;
    @(posedge clk);
    cfg_idx  <= CFG_NUM_PLANES;
    cfg_data <= planes_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes += 3;
  endtask

  task automatic send_voxel(input logic [VOXEL_BITS-1:0] value, input bit burst);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(value);
    do @(posedge clk); while (!s_tready);
    voxels_sent++;
  endtask

  // Hold the input idle until every expected sum has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int run_len;
    int hold;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        // Long stall so the pipeline fills and pushes back on the voxel input
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) :
                                                $urandom_range(1, 12);
        m_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        hold = idle_len();
        if (hold != 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [VOXEL_BITS-1:0] corner_vals [0:24];
    int i;
    int rows;
    int cols;
    int planes;
    int cur_rows;
    int cur_cols;
    int cur_planes;
    int which;
    int vol_items;
    int count;
    int phase_no;
    int rand_items;
    bit big;
    bit single;
    bit burst;

    corner_vals = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'hFFFF, 16'h0001, 16'h5555,
                    16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF,
                    16'h8000, 16'h7FFF, 16'h0F0F, 16'hF0F0,
                    16'h8001, 16'h7FFE,
                    16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2x2 volume at the extremes, then three voxels into the next volume
    set_volume(9'd2, 9'd2, 9'd2);
    for (i = 0; i < 11; i++) send_voxel(corner_vals[i], 1'b0);
    drain();
    // A write of an unchanged value still restarts the scan
    write_reg(CFG_NUM_COLS, 9'd2);
    for (i = 11; i < 19; i++) send_voxel(corner_vals[i], 1'b0);
    drain();
    // Zero dimensions act as one: every voxel ends a volume
    set_volume(9'd0, 9'd0, 9'd0);
    for (i = 19; i < 21; i++) send_voxel(corner_vals[i], 1'b0);
    drain();
    // Oversized dimensions act as the maximum; planes drops bits above its width
    set_volume(9'd511, 9'd300, 9'h1FF);
    for (i = 21; i < 25; i++) send_voxel(corner_vals[i], 1'b0);
    drain();
    cur_rows   = MAX_ROWS;
    cur_cols   = MAX_COLS;
    cur_planes = MAX_PLANES;

    phase_no   = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      big    = 1'b1;
      single = 1'b0;
      if (phase_no == 1) begin
        rows = MAX_ROWS; cols = 1; planes = 1;
      end else if (phase_no == 2) begin
        rows = 2; cols = MAX_COLS; planes = 1;
      end else if (phase_no == 3) begin
        rows = 2; cols = 2; planes = MAX_PLANES;
      end else begin
        big = 1'b0;
        if (cur_rows * cur_cols * cur_planes <= 64 && $urandom_range(0, 3) == 0) begin
          single = 1'b1;
          rows   = cur_rows;
          cols   = cur_cols;
          planes = cur_planes;
          which  = $urandom_range(0, 2);
        end else if ($urandom_range(0, 2) == 0) begin
          rows   = $urandom_range(1, 3);
          cols   = $urandom_range(1, 5);
          planes = $urandom_range(5, 16);
        end else begin
          rows   = $urandom_range(1, 4);
          cols   = $urandom_range(1, 4);
          planes = $urandom_range(1, 4);
        end
      end

      if (single) begin
        case (which)
          0: begin
            rows = $urandom_range(1, 4);
            write_reg(CFG_NUM_ROWS, encode_dim(rows, MAX_ROWS, ROWS_CFG_W));
          end
          1: begin
            cols = $urandom_range(1, 4);
            write_reg(CFG_NUM_COLS, encode_dim(cols, MAX_COLS, COLS_CFG_W));
          end
          default: begin
            planes = $urandom_range(1, 4);
            write_reg(CFG_NUM_PLANES, encode_dim(planes, MAX_PLANES, PLANES_CFG_W));
          end
        endcase
      end else begin
        set_volume(encode_dim(rows, MAX_ROWS, ROWS_CFG_W),
                   encode_dim(cols, MAX_COLS, COLS_CFG_W),
                   encode_dim(planes, MAX_PLANES, PLANES_CFG_W));
      end
      cur_rows   = rows;
      cur_cols   = cols;
      cur_planes = planes;

      vol_items = rows * cols * planes;
      count     = big ? vol_items : vol_items * $urandom_range(1, 3);
      // Sometimes stop partway into a volume; the next write restarts it
      if (!big && $urandom_range(0, 3) == 0) count += $urandom_range(1, vol_items);
      burst = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) hold_off_req = 1'b1;
      for (i = 0; i < count; i++) send_voxel(random_voxel(), burst);
      drain();
      rand_items += count;
      phase_no++;
    end

    $display("summary: %0d voxels over %0d volume settings, %0d register writes",
             voxels_sent, phase_no + 4, reg_writes);
    $display("summary: %0d sums checked, %0d complete volumes, %0d mismatches",
             sums_checked, volumes_done, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
